// ===== rtl/skq_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted key queue package
// Shared types and constants for the sorted key queue and its cells.
// ----------------------------------------------------------------------------
package skq_pkg;

    // Default sizing, handed to the top level as parameter defaults
    localparam int DEPTH_DEF    = 16;
    localparam int KEY_BITS_DEF = 32;

    // Input request fields, packed from bit 0 upward in s_tdata
    localparam int REQ_W       = 3;
    localparam int KEY_W       = 32;
    localparam int POS_W       = 4;
    localparam int REQ_LSB     = 0;
    localparam int KEY_LSB     = REQ_LSB + REQ_W;
    localparam int POS_LSB     = KEY_LSB + KEY_W;
    localparam int IN_FIELDS_W = POS_LSB + POS_W;
    localparam int S_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;

    // Result fields, packed from bit 0 upward in m_tdata
    localparam int OK_W         = 1;
    localparam int VALUE_W      = 32;
    localparam int COUNT_W      = 5;
    localparam int OUT_FIELDS_W = OK_W + VALUE_W + COUNT_W;
    localparam int M_TDATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = M_TDATA_W - OUT_FIELDS_W;

    // Register port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register word index (paddr[2])
    localparam logic REG_ORDER_EN = 1'b0;

    // Request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH   = 3'd0,
        REQ_POP    = 3'd1,
        REQ_INSERT = 3'd2,
        REQ_ERASE  = 3'd3,
        REQ_READ   = 3'd4,
        REQ_CLEAR  = 3'd5
    } req_t;

    // Command broadcast to every cell of the chain
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_WRITE,
        CELL_REMOVE,
        CELL_INSERT
    } cell_op_t;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_INS  = 4'b0010,
        S_ERA  = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

endpackage

// ===== rtl/sorted_key_queue.sv =====
// ----------------------------------------------------------------------------
// Sorted key queue
// Bounded queue of unsigned keys held in a row of cells, with push, pop,
// sorted insert, erase, indexed read and clear requests.
// ----------------------------------------------------------------------------
// The queue holds up to DEPTH keys in a chain of cells, cell 0 being the head.
// Every request gives exactly one result (ok, value, count). Push, pop, read,
// clear and any failed or undefined request update the cells and the result
// registers at the accepting edge; the result then moves into the output
// register once that register is free. Sorted insert walks a scan pointer
// down the chain one cell per cycle until it finds the first entry not
// greater than the key (or the tail), then writes the key there and shifts
// the cells behind it. Erase walks the same pointer over every entry; on a
// match it holds the pointer while the cells behind it close the gap and the
// count drops. The queue takes one request at a time and accepts the next
// one as soon as the previous result sits in the output register, even if
// that result has not been taken yet. Sorted insert and erase fail unless
// order_enabled (register 0, byte address 0) is set. Slot contents are not
// cleared at reset; the entry count is.
// ----------------------------------------------------------------------------
module sorted_key_queue
    import skq_pkg::*;
#(
    parameter int DEPTH    = DEPTH_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    // Request stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // req_type[2:0], key[34:3], position[38:35]

    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // ok[0], value[32:1], count[37:33]

    // Register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    state_t                state_reg,     state_next;
    logic [CNT_W-1:0]      count_reg,     count_next;
    logic [CNT_W-1:0]      ptr_reg,       ptr_next;
    logic [KEY_BITS-1:0]   key_reg,       key_next;
    logic                  hit_reg,       hit_next;
    logic                  res_ok_reg,    res_ok_next;
    logic [VALUE_W-1:0]    res_value_reg, res_value_next;
    logic [COUNT_W-1:0]    res_count_reg, res_count_next;
    logic                  out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0]  out_data_reg,  out_data_next;
    logic                  order_en_reg;

    // ------------------------------------------------------------------------
    // Cell chain
    // ------------------------------------------------------------------------
    cell_op_t              cell_op;
    logic [IDX_W-1:0]      cell_ptr;
    logic [KEY_BITS-1:0]   cell_key;
    logic [KEY_BITS-1:0]   slot_q    [DEPTH];
    logic [KEY_BITS-1:0]   prev_q    [DEPTH];
    logic [KEY_BITS-1:0]   next_q    [DEPTH];
    logic [DEPTH-1:0]      gt_vec;
    logic [DEPTH-1:0]      eq_vec;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            // The ends of the chain feed themselves; those inputs never matter
            if (g == 0)
            begin : g_head
                assign prev_q[g] = slot_q[g];
            end
            else
            begin : g_body
                assign prev_q[g] = slot_q[g-1];
            end

            if (g == DEPTH - 1)
            begin : g_tail
                assign next_q[g] = slot_q[g];
            end
            else
            begin : g_inner
                assign next_q[g] = slot_q[g+1];
            end

            skq_cell #(
                .KEY_BITS (KEY_BITS),
                .IDX_W    (IDX_W),
                .INDEX    (g)
            ) u_cell (
                .clk       (clk),
                .op        (cell_op),
                .ptr       (cell_ptr),
                .key       (cell_key),
                .prev_slot (prev_q[g]),
                .next_slot (next_q[g]),
                .slot      (slot_q[g]),
                .gt        (gt_vec[g]),
                .eq        (eq_vec[g])
            );
        end
    endgenerate

    // ------------------------------------------------------------------------
    // Request fields and status
    // ------------------------------------------------------------------------
    logic [REQ_W-1:0]    in_req;
    logic [KEY_W-1:0]    in_key;
    logic [POS_W-1:0]    in_pos;
    logic [KEY_BITS-1:0] in_key_k;
    logic [IDX_W-1:0]    read_idx;
    logic                read_hit;
    logic                full;
    logic                empty;
    logic [IDX_W-1:0]    ptr_idx;
    logic [IDX_W-1:0]    count_idx;
    logic                out_free;

    assign in_req    = s_tdata[REQ_LSB +: REQ_W];
    assign in_key    = s_tdata[KEY_LSB +: KEY_W];
    assign in_pos    = s_tdata[POS_LSB +: POS_W];
    assign in_key_k  = KEY_BITS'(in_key);
    assign read_idx  = IDX_W'(in_pos);
    assign read_hit  = (CMP_W'(in_pos) < CMP_W'(count_reg));
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign ptr_idx   = ptr_reg[IDX_W-1:0];
    assign count_idx = count_reg[IDX_W-1:0];
    assign out_free  = !out_valid_reg || m_tready;

    // ------------------------------------------------------------------------
    // Controller: decode requests, step the scan pointer, drive the cells
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        key_next       = key_reg;
        hit_next       = hit_reg;
        res_ok_next    = res_ok_reg;
        res_value_next = res_value_reg;
        res_count_next = res_count_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        cell_op        = CELL_HOLD;
        cell_ptr       = '0;
        cell_key       = key_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    // Failed and undefined requests fall through with ok low
                    key_next       = in_key_k;
                    cell_key       = in_key_k;
                    res_ok_next    = 1'b0;
                    res_value_next = '0;
                    state_next     = S_DONE;
                    unique case (req_t'(in_req))
                        REQ_PUSH:
                        begin
                            if (!full)
                            begin
                                cell_op     = CELL_WRITE;
                                cell_ptr    = count_idx;
                                count_next  = count_reg + CNT_W'(1);
                                res_ok_next = 1'b1;
                            end
                        end
                        REQ_POP:
                        begin
                            if (!empty)
                            begin
                                res_value_next = VALUE_W'(slot_q[0]);
                                cell_op        = CELL_REMOVE;
                                cell_ptr       = '0;
                                count_next     = count_reg - CNT_W'(1);
                                res_ok_next    = 1'b1;
                            end
                        end
                        REQ_INSERT:
                        begin
                            if (order_en_reg && !full)
                            begin
                                ptr_next   = '0;
                                state_next = S_INS;
                            end
                        end
                        REQ_ERASE:
                        begin
                            if (order_en_reg && !empty)
                            begin
                                ptr_next   = '0;
                                hit_next   = 1'b0;
                                state_next = S_ERA;
                            end
                        end
                        REQ_READ:
                        begin
                            if (read_hit)
                            begin
                                res_value_next = VALUE_W'(slot_q[read_idx]);
                                res_ok_next    = 1'b1;
                            end
                        end
                        REQ_CLEAR:
                        begin
                            count_next  = '0;
                            res_ok_next = 1'b1;
                        end
                        default:
                        begin
                            res_ok_next = 1'b0;
                        end
                    endcase
                    res_count_next = COUNT_W'(count_next);
                end
            end

            S_INS:
            begin
                // Stop at the first entry not greater than the key, or the tail
                if (ptr_reg == count_reg || !gt_vec[ptr_idx])
                begin
                    cell_op        = CELL_INSERT;
                    cell_ptr       = ptr_idx;
                    count_next     = count_reg + CNT_W'(1);
                    res_ok_next    = 1'b1;
                    res_count_next = COUNT_W'(count_reg + CNT_W'(1));
                    state_next     = S_DONE;
                end
                else
                begin
                    ptr_next = ptr_reg + CNT_W'(1);
                end
            end

            S_ERA:
            begin
                if (ptr_reg == count_reg)
                begin
                    res_ok_next    = hit_reg;
                    res_count_next = COUNT_W'(count_reg);
                    state_next     = S_DONE;
                end
                else if (eq_vec[ptr_idx])
                begin
                    // Drop the match and hold the pointer: the next entry
                    // slides into this cell
                    cell_op    = CELL_REMOVE;
                    cell_ptr   = ptr_idx;
                    count_next = count_reg - CNT_W'(1);
                    hit_next   = 1'b1;
                end
                else
                begin
                    ptr_next = ptr_reg + CNT_W'(1);
                end
            end

            S_DONE:
            begin
                // Hand the result to the output register once it is free
                if (out_free)
                begin
                    out_data_next  = {{OUT_PAD_W{1'b0}}, res_count_reg,
                                      res_value_reg, res_ok_reg};
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and scan registers need no reset
    always_ff @(posedge clk)
    begin
        ptr_reg       <= ptr_next;
        key_reg       <= key_next;
        hit_reg       <= hit_next;
        res_ok_reg    <= res_ok_next;
        res_value_reg <= res_value_next;
        res_count_reg <= res_count_next;
        out_data_reg  <= out_data_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // ------------------------------------------------------------------------
    // Register port: order_enabled at word index 0
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_en_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_ORDER_EN))
        begin
            order_en_reg <= pwdata[0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ORDER_EN) ? APB_DATA_W'(order_en_reg) : '0;

endmodule

// ===== rtl/skq_cell.sv =====
// ----------------------------------------------------------------------------
// Sorted key queue cell
// Holds one key, compares it against the broadcast key and takes a key from
// the broadcast bus or from a neighbor cell as the command asks.
// ----------------------------------------------------------------------------
module skq_cell
    import skq_pkg::*;
#(
    parameter int KEY_BITS = KEY_BITS_DEF,
    parameter int IDX_W    = 4,
    parameter int INDEX    = 0
)
(
    input  logic                clk,
    input  cell_op_t            op,
    input  logic [IDX_W-1:0]    ptr,
    input  logic [KEY_BITS-1:0] key,
    input  logic [KEY_BITS-1:0] prev_slot,
    input  logic [KEY_BITS-1:0] next_slot,
    output logic [KEY_BITS-1:0] slot,
    output logic                gt,
    output logic                eq
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [KEY_BITS-1:0] slot_reg;
    logic [KEY_BITS-1:0] slot_next;
    logic                at_ptr;
    logic                past_ptr;

    assign at_ptr   = (MY_IDX == ptr);
    assign past_ptr = (MY_IDX > ptr);

    always_comb
    begin
        slot_next = slot_reg;
        case (op)
            CELL_WRITE:
            begin
                if (at_ptr)
                begin
                    slot_next = key;
                end
            end
            CELL_REMOVE:
            begin
                // close the gap: this cell and all behind it pull from the next
                if (at_ptr || past_ptr)
                begin
                    slot_next = next_slot;
                end
            end
            CELL_INSERT:
            begin
                // open a gap: cells behind the slot pull from the previous one
                if (at_ptr)
                begin
                    slot_next = key;
                end
                else if (past_ptr)
                begin
                    slot_next = prev_slot;
                end
            end
            default:
            begin
                slot_next = slot_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    assign slot = slot_reg;
    assign gt   = (slot_reg > key);
    assign eq   = (slot_reg == key);

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// Sorted key queue testbench
// Streams push, pop, sorted insert, erase, read, clear and undefined requests
// into the queue while the result side applies random backpressure. A local
// copy of the queue state predicts every result, and each result is checked
// field by field in arrival order.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import skq_pkg::*;

    localparam int QDEPTH           = DEPTH_DEF;
    localparam int SINK_HOLD_CYCLES = 400;    // long receiver hold-off
    localparam int WATCHDOG_LIMIT   = 3000;   // cycles without any transfer
    localparam int DRAIN_CYCLES     = 64;     // quiet time before the verdict
    localparam int REPORT_LIMIT     = 100;

    // req_type codes the block does not define; they still give a result
    localparam logic [REQ_W-1:0] REQ_RSVD_LO = 3'd6;
    localparam logic [REQ_W-1:0] REQ_RSVD_HI = 3'd7;

    // order_enabled sits at word 0 of the register port
    localparam logic [APB_ADDR_W-1:0] ORDER_EN_ADDR = {REG_ORDER_EN, 2'b00};

    typedef struct packed {
        logic               ok;
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] count;
    } result_t;

    typedef enum logic [1:0] {
        SINK_ALWAYS,
        SINK_COIN,
        SINK_SPARSE,
        SINK_PATTERN
    } sink_mode_e;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;   // req_type[2:0], key[34:3], position[38:35]
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;         // ok[0], value[32:1], count[37:33]
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Local copy of the queue: keys, entry count and the ordering switch
    logic [KEY_W-1:0] q_keys [QDEPTH];
    int unsigned      q_len    = 0;
    logic             order_en = 1'b0;

    // Results owed by the block, oldest first
    result_t expected_results [$];
    int      errors = 0;

    // Sender pacing
    int burst_left = 0;
    int gap_max    = 0;

    // Receiver pacing
    sink_mode_e sink_mode      = SINK_ALWAYS;
    int         sink_mode_left = 0;
    logic [2:0] sink_phase     = '0;
    logic       sink_hold_req  = 1'b0;
    int         sink_hold_left = 0;

    int stall_cycles = 0;

    sorted_key_queue DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------------
    // Queue behavior: apply one request to the local copy and return the
    // result the block must give for it.
    // ------------------------------------------------------------------------
    function automatic result_t apply_request(input logic [REQ_W-1:0] req,
                                              input logic [KEY_W-1:0] key,
                                              input logic [POS_W-1:0] pos);
        result_t     r;
        int unsigned at;
        int unsigned w;
        int unsigned i;
        r = '0;
        case (req)
            REQ_PUSH:
                if (q_len < QDEPTH)
                begin
                    q_keys[q_len] = key;
                    q_len++;
                    r.ok = 1'b1;
                end
            REQ_POP:
                if (q_len != 0)
                begin
                    r.value = q_keys[0];
                    for (i = 1; i < q_len; i++)
                        q_keys[i-1] = q_keys[i];
                    q_len--;
                    r.ok = 1'b1;
                end
            REQ_INSERT:
                if (order_en && q_len < QDEPTH)
                begin
                    // descending order; a new key goes ahead of equal keys
                    at = 0;
                    while (at < q_len && q_keys[at] > key)
                        at++;
                    for (i = q_len; i > at; i--)
                        q_keys[i] = q_keys[i-1];
                    q_keys[at] = key;
                    q_len++;
                    r.ok = 1'b1;
                end
            REQ_ERASE:
                if (order_en && q_len != 0)
                begin
                    w = 0;
                    for (i = 0; i < q_len; i++)
                    begin
                        if (q_keys[i] == key)
                            r.ok = 1'b1;
                        else
                        begin
                            q_keys[w] = q_keys[i];
                            w++;
                        end
                    end
                    q_len = w;
                end
            REQ_READ:
                if (pos < q_len)
                begin
                    r.value = q_keys[pos];
                    r.ok    = 1'b1;
                end
            REQ_CLEAR:
            begin
                q_len = 0;
                r.ok  = 1'b1;
            end
            default:
                ;
        endcase
        r.count = COUNT_W'(q_len);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Sender: offer one request, pausing between random-length bursts, and
    // record the expected result once the request is taken.
    // ------------------------------------------------------------------------
    task automatic send_request(input logic [REQ_W-1:0] req,
                                input logic [KEY_W-1:0] key,
                                input logic [POS_W-1:0] pos);
        logic [S_TDATA_W-1:0] word;
        int                   gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap        = $urandom_range(0, gap_max);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        word                     = '0;
        word[REQ_LSB +: REQ_W]   = req;
        word[KEY_LSB +: KEY_W]   = key;
        word[POS_LSB +: POS_W]   = pos;
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do
            @(posedge clk);
        while (!s_tready);
        expected_results.push_back(apply_request(req, key, pos));
    endtask

    // Drop valid and hold until every owed result has come back
    task automatic wait_queue_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write order_enabled through the register port (setup, then access)
    task automatic write_order_enable(input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ORDER_EN_ADDR;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        order_en  = data[0];
    endtask

    task automatic set_ordering(input logic [APB_DATA_W-1:0] data);
        wait_queue_idle();
        write_order_enable(data);
    endtask

    // Favor a dense pool of small keys so equal keys meet often
    function automatic logic [KEY_W-1:0] pick_key();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return KEY_W'($urandom_range(0, 7));
            5:
                if (q_len != 0)
                    return q_keys[$urandom_range(0, q_len - 1)];
                else
                    return $urandom;
            default: return $urandom;
        endcase
    endfunction

    // One random request; grow_pct is the chance of a push or insert
    task automatic random_request(input int grow_pct);
        logic [REQ_W-1:0] req;
        logic [KEY_W-1:0] key;
        logic [POS_W-1:0] pos;
        int               roll;
        key  = pick_key();
        pos  = POS_W'($urandom_range(0, 15));
        roll = $urandom_range(0, 99);
        if (roll < grow_pct)
            req = $urandom_range(0, 1) ? REQ_INSERT : REQ_PUSH;
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < 40)
                req = REQ_POP;
            else if (roll < 60)
            begin
                req = REQ_ERASE;
                if (q_len != 0 && $urandom_range(0, 3) != 0)
                    key = q_keys[$urandom_range(0, q_len - 1)];
            end
            else if (roll < 88)
            begin
                req = REQ_READ;
                if (q_len != 0 && $urandom_range(0, 3) != 0)
                    pos = POS_W'($urandom_range(0, q_len - 1));
            end
            else if (roll < 95)
                req = REQ_CLEAR;
            else
                req = $urandom_range(0, 1) ? REQ_RSVD_HI : REQ_RSVD_LO;
        end
        send_request(req, key, pos);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Edge cases: empty queue, ordering off and on, extreme keys, equal keys,
    // reads past the tail, undefined codes
    task automatic test_directed();
        gap_max = 2;
        // ordering is off after reset
        send_request(REQ_POP,     '0,           '0);
        send_request(REQ_READ,    '0,           4'hF);
        send_request(REQ_INSERT,  '1,           '0);
        send_request(REQ_RSVD_LO, '1,           4'hF);
        send_request(REQ_RSVD_HI, 32'h5A5A_A5A5, 4'h5);
        send_request(REQ_PUSH,    '1,           '0);
        send_request(REQ_ERASE,   '1,           '0);
        // all-ones data still means just "on"
        set_ordering(32'hFFFF_FFFF);
        send_request(REQ_ERASE,   '0,           '0);
        send_request(REQ_INSERT,  '0,           '0);
        send_request(REQ_INSERT,  '1,           '0);
        send_request(REQ_INSERT,  32'h8000_0000, '0);
        send_request(REQ_READ,    '0,           4'd3);
        send_request(REQ_READ,    '0,           4'd4);
        send_request(REQ_ERASE,   '1,           '0);
        send_request(REQ_POP,     '0,           '0);
        send_request(REQ_CLEAR,   '0,           '0);
        send_request(REQ_ERASE,   '0,           '0);
        send_request(REQ_CLEAR,   '1,           4'hF);
    endtask

    task automatic test_random_mix(input int n, input int grow_pct, input int gaps);
        gap_max = gaps;
        repeat (n) random_request(grow_pct);
    endtask

    // Run the queue up to full, push against it, then drain past empty.
    // No sender gaps here, so requests arrive back to back.
    task automatic test_fill_drain(input int rounds);
        gap_max = 0;
        repeat (rounds)
        begin
            while (q_len < QDEPTH)
                random_request(90);
            repeat (4) random_request(95);
            while (q_len != 0)
                random_request(10);
            repeat (3) random_request(5);
        end
    endtask

    // Hold the result side off for a long stretch while requests keep coming,
    // so the block backs up and stalls its input; then pause until drained
    task automatic test_input_stall();
        gap_max        = 0;
        sink_hold_req <= 1'b1;
        repeat (40) random_request(50);
        wait_queue_idle();
    endtask

    // ------------------------------------------------------------------------
    // Receiver: long hold-off on request, else a random ready pattern that
    // changes mode at the end of each randomly drawn run of cycles
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (sink_hold_left != 0)
        begin
            sink_hold_left <= sink_hold_left - 1;
            m_tready       <= 1'b0;
        end
        else if (sink_hold_req)
        begin
            sink_hold_req  <= 1'b0;
            sink_hold_left <= SINK_HOLD_CYCLES;
            m_tready       <= 1'b0;
        end
        else
        begin
            if (sink_mode_left == 0)
            begin
                sink_mode      <= sink_mode_e'($urandom_range(0, 3));
                sink_mode_left <= $urandom_range(20, 200);
            end
            else
                sink_mode_left <= sink_mode_left - 1;
            sink_phase <= sink_phase + 3'd1;
            case (sink_mode)
                SINK_ALWAYS: m_tready <= 1'b1;
                SINK_COIN:   m_tready <= 1'($urandom_range(0, 1));
                SINK_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                default:     m_tready <= (sink_phase < 3'd5);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Result check: compare each accepted result with the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        result_t got;
        result_t want;
        if (m_tvalid && m_tready)
        begin
            got.ok    = m_tdata[0];
            got.value = m_tdata[OK_W +: VALUE_W];
            got.count = m_tdata[OK_W + VALUE_W +: COUNT_W];
            if (expected_results.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("%0t: unexpected result ok=%0d value=%h count=%0d",
                             $time, got.ok, got.value, got.count);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got !== want)
                begin
                    errors++;
                    // keep the log short once a run has clearly gone wrong
                    if (errors <= REPORT_LIMIT)
                    begin
                        if (got.ok !== want.ok)
                            $display("%0t: ok expected %0d got %0d",
                                     $time, want.ok, got.ok);
                        if (got.value !== want.value)
                            $display("%0t: value expected %h got %h",
                                     $time, want.value, got.value);
                        if (got.count !== want.count)
                            $display("%0t: count expected %0d got %0d",
                                     $time, want.count, got.count);
                    end
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves on any port for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                     $time, stall_cycles, expected_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_mix(600, 55, 3);
        test_fill_drain(8);
        test_input_stall();
        // upper bits set, bit 0 clear: ordering off
        set_ordering(32'hFFFF_FFFE);
        test_random_mix(300, 50, 6);
        set_ordering(32'h0000_0001);
        test_random_mix(340, 55, 8);

        wait_queue_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sorted_key_queue.f =====
rtl/skq_pkg.sv
rtl/skq_cell.sv
rtl/sorted_key_queue.sv
verif/tb.sv
